### rtl/core/apc_pkg.sv
package apc_pkg;

    localparam int ADC_W   = 16;
    localparam int COEF_W  = 64;
    localparam int ENERGY_W = 32;
    localparam int HITS_W  = 14;
    localparam int TOTAL_W = 40;
    localparam int PED_W   = 16;
    localparam int CH_W    = 13;
    localparam int TB_W    = 2;
    localparam int CI_W    = 3;
    localparam int RAW_W   = 12;
    localparam int ACT_W   = 3;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;

    localparam logic [ACT_W-1:0] ACT_WR_PED  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WR_COEF = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WR_GOOD = 3'd2;
    localparam logic [ACT_W-1:0] ACT_HIT     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_END     = 3'd4;

    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    typedef struct packed {
        logic signed [COEF_W-1:0] acc;
        logic [ADC_W-1:0]         x;
        logic signed [COEF_W-1:0] coef;
    } apc_req_t;

endpackage

### rtl/core/adc_pedestal_polynomial_calibrator.sv
// channel   direction  handshake                   content
// s_axis    in         s_axis_tvalid/tready        one table write, hit or end of event
// m_axis    out        m_axis_tvalid/tready        one hit result or event totals
// cfg       in         cfg_we                      pedestal enable bit
//
// table writes end in S_EXEC; an end of event or a hit waits in S_EMIT for the output
// a good-channel hit runs horner steps between S_HIT_RD and S_FINISH, other hits skip them
//   each step: S_STEP_START, H_LO, H_HI, H_MAG and H_ADD in the shared 32x16 multiplier
//   unit, S_STEP_WAIT to take its result; coefficient memory feeds one term at a time
// after reset the good-flag memory is cleared, one channel a cycle, through all CHANNELS
//   entries with s_axis_tready low
// a new item is taken while the previous result waits in the output register
module adc_pedestal_polynomial_calibrator #(
    parameter int CHANNELS   = 8192,
    parameter int TIME_BINS  = 4,
    parameter int POLY_TERMS = 5,
    parameter int ADC_BITS   = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // channel, time_bin, coef_index, table_value, raw_adc, zero pad
    input  logic [95:0]  s_axis_tdata,
    // action
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // corrected_adc, energy, calibrated, hit_count, total_energy, zero pad
    output logic [103:0] m_axis_tdata,
    // kind
    output logic         m_axis_tuser
);

    import apc_pkg::*;

    localparam int PED_DEPTH  = CHANNELS * TIME_BINS;
    localparam int COEF_DEPTH = CHANNELS * POLY_TERMS;
    localparam int PAW = $clog2(PED_DEPTH);
    localparam int CAW = $clog2(COEF_DEPTH);
    localparam int GAW = $clog2(CHANNELS);
    localparam int KW  = (POLY_TERMS > 2) ? $clog2(POLY_TERMS) : 1;
    localparam int RAW_USE = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((64'd1 << RAW_USE) - 64'd1);
    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_HIT_RD, S_STEP_START, S_STEP_WAIT, S_FINISH, S_EMIT
    } state_t;

    state_t              state_reg;
    logic [GAW-1:0]      clr_cnt_reg;
    logic                ped_en_reg;
    logic [ACT_W-1:0]    act_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [TB_W-1:0]     tb_reg;
    logic [CI_W-1:0]     ci_reg;
    logic [63:0]         tv_reg;
    logic [RAW_W-1:0]    raw_reg;
    logic [ADC_W-1:0]    adc_reg;
    logic                good_reg;
    logic signed [63:0]  acc_reg;
    logic [KW-1:0]       k_reg;
    logic                kind_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [HITS_W-1:0]   hits_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [HITS_W-1:0]   res_hits_reg;
    logic [TOTAL_W-1:0]  res_total_reg;
    logic                m_valid_reg;
    logic [103:0]        m_data_reg;
    logic                m_user_reg;

    logic                ch_ok;
    logic                tb_ok;
    logic [PAW-1:0]      ped_addr;
    logic                ped_we;
    logic [PED_W-1:0]    ped_rdata;
    logic [CAW-1:0]      coef_addr;
    logic                coef_we;
    logic [63:0]         coef_rdata;
    logic [GAW-1:0]      good_addr;
    logic                good_we;
    logic                good_wdata;
    logic                good_rdata;
    logic [31:0]         coef_idx;
    logic [ADC_W-1:0]    adc_raw_q;
    logic [ADC_W-1:0]    adc_corr;
    logic [ENERGY_W-1:0] energy_w;
    logic [TOTAL_W:0]    total_sum;
    logic                h_start;
    apc_req_t            h_req;
    logic                h_done;
    logic signed [63:0]  h_result;

    assign ch_ok = 32'(ch_reg) < CHANNELS;
    assign tb_ok = 32'(tb_reg) < TIME_BINS;

    assign ped_addr = PAW'(32'(ch_reg) * TIME_BINS + 32'(tb_reg));
    assign ped_we   = (state_reg == S_EXEC) && (act_reg == ACT_WR_PED) && ch_ok && tb_ok;

    always_comb
    begin
        case (state_reg)
            S_EXEC:   coef_idx = (act_reg == ACT_WR_COEF) ? 32'(ci_reg) : 32'(POLY_TERMS - 1);
            S_HIT_RD: coef_idx = 32'(POLY_TERMS - 2);
            default:  coef_idx = 32'(k_reg) - 32'd1;
        endcase
    end
    assign coef_addr = CAW'(32'(ch_reg) * POLY_TERMS + coef_idx);
    assign coef_we   = (state_reg == S_EXEC) && (act_reg == ACT_WR_COEF) && ch_ok
                       && (32'(ci_reg) < POLY_TERMS);

    assign good_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg : GAW'(ch_reg);
    assign good_we    = (state_reg == S_CLEAR)
                        || ((state_reg == S_EXEC) && (act_reg == ACT_WR_GOOD) && ch_ok);
    assign good_wdata = (state_reg == S_CLEAR) ? 1'b0 : tv_reg[0];

    apc_ram #(.WIDTH(PED_W), .DEPTH(PED_DEPTH)) u_ped_ram (
        .clk   (clk),
        .we    (ped_we),
        .addr  (ped_addr),
        .wdata (tv_reg[PED_W-1:0]),
        .rdata (ped_rdata)
    );

    apc_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .addr  (coef_addr),
        .wdata (tv_reg),
        .rdata (coef_rdata)
    );

    apc_ram #(.WIDTH(1), .DEPTH(CHANNELS)) u_good_ram (
        .clk   (clk),
        .we    (good_we),
        .addr  (good_addr),
        .wdata (good_wdata),
        .rdata (good_rdata)
    );

    // pedestal subtraction clamped at zero, bypassed when the pedestal enable bit is clear
    always_comb
    begin
        logic [PED_W-1:0] ped;
        ped       = (ch_ok && tb_ok) ? ped_rdata : '0;
        adc_raw_q = ADC_W'(raw_reg & RAW_MASK) << 4;
        adc_corr  = adc_raw_q;
        if (ped_en_reg)
        begin
            adc_corr = (adc_raw_q > ped) ? (adc_raw_q - ped) : '0;
        end
    end

    assign h_start    = (state_reg == S_STEP_START);
    assign h_req.acc  = acc_reg;
    assign h_req.x    = adc_reg;
    assign h_req.coef = coef_rdata;

    apc_horner u_horner (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (h_start),
        .req    (h_req),
        .done   (h_done),
        .result (h_result)
    );

    assign energy_w  = (good_reg && !acc_reg[63] && acc_reg != 0) ? acc_reg[63:32] : '0;
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(energy_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            ped_en_reg  <= 1'b1;
            hits_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ped_en_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_axis_tready && (state_reg != S_EMIT))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == GAW'(CHANNELS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        act_reg   <= s_axis_tuser;
                        ch_reg    <= s_axis_tdata[12:0];
                        tb_reg    <= s_axis_tdata[14:13];
                        ci_reg    <= s_axis_tdata[17:15];
                        tv_reg    <= s_axis_tdata[81:18];
                        raw_reg   <= s_axis_tdata[93:82];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    case (act_reg)
                        ACT_HIT:
                        begin
                            state_reg <= S_HIT_RD;
                        end
                        ACT_END:
                        begin
                            kind_reg      <= KIND_EVENT;
                            adc_reg       <= '0;
                            energy_reg    <= '0;
                            good_reg      <= 1'b0;
                            res_hits_reg  <= hits_reg;
                            res_total_reg <= total_reg;
                            hits_reg      <= '0;
                            total_reg     <= '0;
                            state_reg     <= S_EMIT;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_HIT_RD:
                begin
                    adc_reg  <= adc_corr;
                    good_reg <= ch_ok && good_rdata;
                    acc_reg  <= coef_rdata;
                    k_reg    <= KW'(POLY_TERMS - 2);
                    if (ch_ok && good_rdata && POLY_TERMS > 1)
                    begin
                        state_reg <= S_STEP_START;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_STEP_START:
                begin
                    state_reg <= S_STEP_WAIT;
                end
                S_STEP_WAIT:
                begin
                    if (h_done)
                    begin
                        acc_reg <= h_result;
                        if (k_reg == '0)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            k_reg     <= k_reg - 1'b1;
                            state_reg <= S_STEP_START;
                        end
                    end
                end
                S_FINISH:
                begin
                    kind_reg   <= KIND_HIT;
                    energy_reg <= energy_w;
                    if (good_reg)
                    begin
                        res_hits_reg  <= (hits_reg != HITS_MAX) ? hits_reg + 1'b1 : hits_reg;
                        hits_reg      <= (hits_reg != HITS_MAX) ? hits_reg + 1'b1 : hits_reg;
                        res_total_reg <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                        total_reg     <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                    end
                    else
                    begin
                        res_hits_reg  <= hits_reg;
                        res_total_reg <= total_reg;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= kind_reg;
                        m_data_reg  <= {1'b0, res_total_reg, res_hits_reg, good_reg,
                                        energy_reg, adc_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

### rtl/core/apc_ram.sv
module apc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/core/apc_horner.sv
module apc_horner (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  apc_pkg::apc_req_t              req,
    output logic                           done,
    output logic signed [apc_pkg::COEF_W-1:0] result
);

    import apc_pkg::*;

    typedef enum logic [2:0] {H_IDLE, H_LO, H_HI, H_MAG, H_ADD} hstate_t;

    localparam int PROD_W = 32 + ADC_W;
    localparam logic [63:0] POS_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] NEG_MAX = {1'b1, {63{1'b0}}};

    hstate_t            state_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic [ADC_W-1:0]   x_reg;
    logic [63:0]        coef_reg;
    logic [PROD_W-1:0]  lo_reg;
    logic [PROD_W-1:0]  hi_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        result_reg;
    logic               done_reg;

    logic [31:0]        mul_a;
    logic [PROD_W-1:0]  mul_p;
    logic [63:0]        s_w;
    logic [63:0]        s_sat;
    logic [63:0]        sum_w;
    logic [63:0]        add_sat;

    assign mul_a = (state_reg == H_LO) ? mag_reg[31:0] : mag_reg[63:32];
    assign mul_p = PROD_W'(mul_a) * PROD_W'(x_reg);

    // magnitude product realigned from q16.48 x q12.4
    assign s_w   = (64'(hi_reg) << 28) + 64'(lo_reg >> 4);
    assign s_sat = ((hi_reg >> 35) != '0 || s_w[63]) ? POS_MAX : s_w;

    assign sum_w = prod_reg + coef_reg;
    always_comb
    begin
        add_sat = sum_w;
        if (prod_reg[63] == coef_reg[63] && sum_w[63] != prod_reg[63])
        begin
            add_sat = prod_reg[63] ? NEG_MAX : POS_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg   <= req.acc[63];
                        mag_reg   <= req.acc[63] ? (64'd0 - req.acc) : req.acc;
                        x_reg     <= req.x;
                        coef_reg  <= req.coef;
                        state_reg <= H_LO;
                    end
                end
                H_LO:
                begin
                    lo_reg    <= mul_p;
                    state_reg <= H_HI;
                end
                H_HI:
                begin
                    hi_reg    <= mul_p;
                    state_reg <= H_MAG;
                end
                H_MAG:
                begin
                    prod_reg  <= neg_reg ? (64'd0 - s_sat) : s_sat;
                    state_reg <= H_ADD;
                end
                H_ADD:
                begin
                    result_reg <= add_sat;
                    done_reg   <= 1'b1;
                    state_reg  <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
